// ===== rtl/sbms_pkg.sv =====
// Shared constants, register codes and the configuration bundle for the bin magnitude stitcher.
package sbms_pkg;

	localparam int DEF_MAX_FFT_LOG2 = 14;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam int LOG2_W = 5;
	localparam int SIZE_REG_W = 4;
	localparam int SEG_W = 8;
	localparam int OVL_W = 13;
	localparam int DISP_W = 16;
	localparam int LEVEL_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FFT_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY = 2'd3;

	localparam logic [SIZE_REG_W-1:0] RST_FFT_LOG2 = 4'd10;
	localparam logic [SIZE_REG_W-1:0] RST_CELLS_LOG2 = 4'd8;
	localparam logic [OVL_W-1:0] RST_OVERLAP = 13'd32;
	localparam logic [DISP_W-1:0] RST_DISPLAY = 16'd4096;

	typedef struct packed {
		logic [LOG2_W-1:0] fft_log2;
		logic [LOG2_W-1:0] cells_log2;
		logic [LOG2_W-1:0] gshift;
		logic [OVL_W-1:0] overlap;
		logic [DISP_W-1:0] display_size;
		logic clear;
	} cfg_t;

endpackage

// ===== rtl/spectrum_bin_magnitude_stitcher_top.sv =====
// Top level of the spectrum bin magnitude stitcher: configuration registers and block wiring.
// An accepted bin passes through the queue, the absolute-value, square and root stages and the output register.
// Throughput: one bin per cycle unless the output stalls; the root is one result bit per pipeline stage.
// A result appears only on the last bin of a group; other bins yield none.
// Reset restores register defaults and clears the bin position, group sum and queue.
module spectrum_bin_magnitude_stitcher_top #(
	parameter int MAX_FFT_LOG2 = sbms_pkg::DEF_MAX_FFT_LOG2,
	parameter int SAMPLE_WIDTH = sbms_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sbms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [SAMPLE_WIDTH-1:0] bin_re,
	input  logic [SAMPLE_WIDTH-1:0] bin_im,
	input  logic [sbms_pkg::SEG_W-1:0] segment_number,
	output logic out_valid,
	input  logic out_stall,
	output logic [sbms_pkg::DISP_W-1:0] display_index,
	output logic [sbms_pkg::LEVEL_W-1:0] level
);
	import sbms_pkg::*;

	localparam int QW = 2 * SAMPLE_WIDTH + SEG_W + MAX_FFT_LOG2 + 1;

	logic [SIZE_REG_W-1:0] fft_log2_q;
	logic [SIZE_REG_W-1:0] cells_log2_q;
	logic [OVL_W-1:0] overlap_q;
	logic [DISP_W-1:0] display_q;
	logic cfg_wr;
	logic [LOG2_W-1:0] f_raw;
	logic [LOG2_W-1:0] c_raw;
	logic [LOG2_W-1:0] f_eff;
	logic [LOG2_W-1:0] c_eff;
	cfg_t cfg;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;
	logic [QW-1:0] push_data;
	logic [QW-1:0] head_data;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_log2_q <= RST_FFT_LOG2;
			cells_log2_q <= RST_CELLS_LOG2;
			overlap_q <= RST_OVERLAP;
			display_q <= RST_DISPLAY;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FFT_LOG2: fft_log2_q <= cfg_data[SIZE_REG_W-1:0];
				REG_CELLS_LOG2: cells_log2_q <= cfg_data[SIZE_REG_W-1:0];
				REG_OVERLAP: overlap_q <= cfg_data[OVL_W-1:0];
				REG_DISPLAY: display_q <= cfg_data[DISP_W-1:0];
				default: ;
			endcase
		end
	end

	assign f_raw = LOG2_W'(fft_log2_q);
	assign c_raw = LOG2_W'(cells_log2_q);

	always_comb begin
		if (f_raw < LOG2_W'(2)) begin
			f_eff = LOG2_W'(2);
		end else if (f_raw > LOG2_W'(MAX_FFT_LOG2)) begin
			f_eff = LOG2_W'(MAX_FFT_LOG2);
		end else begin
			f_eff = f_raw;
		end
		if (c_raw < LOG2_W'(1)) begin
			c_eff = LOG2_W'(1);
		end else if (c_raw > f_eff) begin
			c_eff = f_eff;
		end else begin
			c_eff = c_raw;
		end
	end

	assign cfg.fft_log2 = f_eff;
	assign cfg.cells_log2 = c_eff;
	assign cfg.gshift = f_eff - c_eff;
	assign cfg.overlap = overlap_q;
	assign cfg.display_size = display_q;
	assign cfg.clear = cfg_wr && (cfg_index == REG_FFT_LOG2 || cfg_index == REG_CELLS_LOG2);

	sbms_front #(
		.MAX_FFT_LOG2(MAX_FFT_LOG2),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bin_re(bin_re),
		.bin_im(bin_im),
		.segment_number(segment_number),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	sbms_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head_data(head_data),
		.full(q_full),
		.not_empty(q_not_empty)
	);

	sbms_back #(
		.MAX_FFT_LOG2(MAX_FFT_LOG2),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_not_empty),
		.q_data(head_data),
		.q_pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.display_index(display_index),
		.level(level)
	);

endmodule

// ===== rtl/sbms_front.sv =====
// Front end: accepts bins, tracks position in the segment and classifies group end and cell.
module sbms_front #(
	parameter int MAX_FFT_LOG2 = sbms_pkg::DEF_MAX_FFT_LOG2,
	parameter int SAMPLE_WIDTH = sbms_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  sbms_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  logic [SAMPLE_WIDTH-1:0] bin_re,
	input  logic [SAMPLE_WIDTH-1:0] bin_im,
	input  logic [sbms_pkg::SEG_W-1:0] segment_number,
	input  logic q_full,
	output logic push,
	output logic [2*SAMPLE_WIDTH+sbms_pkg::SEG_W+MAX_FFT_LOG2:0] push_data
);
	import sbms_pkg::*;

	localparam int MF = MAX_FFT_LOG2;

	logic [MF-1:0] bin_count_q;
	logic [MF-1:0] ones;
	logic [MF-1:0] fmask;
	logic [MF-1:0] gmask;
	logic [MF-1:0] cmask;
	logic [MF-1:0] half;
	logic [MF-1:0] pos;
	logic [MF-1:0] cell_idx;
	logic last;

	assign ones = {MF{1'b1}};
	assign fmask = ~(ones << cfg.fft_log2);
	assign gmask = ~(ones << cfg.gshift);
	assign cmask = ~(ones << cfg.cells_log2);
	assign half = MF'(1) << (cfg.cells_log2 - LOG2_W'(1));
	assign pos = bin_count_q & fmask;
	assign last = (pos & gmask) == gmask;
	assign cell_idx = ((pos >> cfg.gshift) ^ half) & cmask;

	assign in_stall = q_full;
	assign push = in_valid && !q_full;
	assign push_data = {bin_re, bin_im, segment_number, last, cell_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= '0;
		end else if (cfg.clear) begin
			bin_count_q <= '0;
		end else if (push) begin
			bin_count_q <= (pos + MF'(1)) & fmask;
		end
	end

endmodule

// ===== rtl/sbms_queue.sv =====
// Short register queue that decouples the front end from the magnitude back end.
module sbms_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sbms_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] head_data,
	output logic full,
	output logic not_empty
);
	import sbms_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count did not advance on push");

endmodule

// ===== rtl/sbms_back.sv =====
// Back end: magnitude pipeline with staged root, group accumulator and overlap stitching.
module sbms_back #(
	parameter int MAX_FFT_LOG2 = sbms_pkg::DEF_MAX_FFT_LOG2,
	parameter int SAMPLE_WIDTH = sbms_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  sbms_pkg::cfg_t cfg,
	input  logic q_valid,
	input  logic [2*SAMPLE_WIDTH+sbms_pkg::SEG_W+MAX_FFT_LOG2:0] q_data,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [sbms_pkg::DISP_W-1:0] display_index,
	output logic [sbms_pkg::LEVEL_W-1:0] level
);
	import sbms_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int MF = MAX_FFT_LOG2;
	localparam int QW = 2 * SW + SEG_W + MF + 1;
	localparam int R = SW + 1;
	localparam int SQW = 2 * SW;
	localparam int RADW = 2 * R;
	localparam int REMW = R + 2;
	localparam int TW = REMW + 2;
	localparam int DW = ((MF + 1) > OVL_W ? (MF + 1) : OVL_W) + 1;
	localparam int IW = DW + SEG_W + 2;
	localparam int SUMW = MF + SW;

	logic en;
	logic [SW-1:0] re_in;
	logic [SW-1:0] im_in;
	logic [SEG_W-1:0] seg_in;
	logic last_in;
	logic [MF-1:0] cell_in;

	logic [MF:0] s_cells;
	logic [DW-1:0] sdiff;
	logic [DW-1:0] cell_x;
	logic [DW-1:0] v_x;
	logic [DW-1:0] hv_x;
	logic [DW-1:0] hv2_x;
	logic signed [IW-1:0] prod_c;
	logic signed [IW-1:0] cv_c;
	logic keep_c;

	logic v_s1;
	logic v_s2;
	logic [SW-1:0] re_abs_s1;
	logic [SW-1:0] im_abs_s1;
	logic last_s1;
	logic keep_s1;
	logic signed [IW-1:0] prod_s1;
	logic signed [IW-1:0] cv_s1;
	logic [SQW-1:0] sq_re_s2;
	logic [SQW-1:0] sq_im_s2;
	logic last_s2;
	logic keep_s2;
	logic signed [IW-1:0] idx_s2;

	logic [R:0] rt_v_s;
	logic [RADW-1:0] rt_rad_s [R+1];
	logic [REMW-1:0] rt_rem_s [R+1];
	logic [R-1:0] rt_root_s [R+1];
	logic rt_last_s [R+1];
	logic rt_ok_s [R+1];
	logic [DISP_W-1:0] rt_idx_s [R+1];

	logic [SUMW-1:0] sum_q;
	logic [SUMW-1:0] sum_next;
	logic out_valid_q;
	logic [DISP_W-1:0] display_index_q;
	logic [LEVEL_W-1:0] level_q;

	function automatic logic [SAMPLE_WIDTH-1:0] mag_abs(input logic [SAMPLE_WIDTH-1:0] x);
		return x[SAMPLE_WIDTH-1] ? (~x + SAMPLE_WIDTH'(1)) : x;
	endfunction

	assign en = !(out_valid_q && out_stall);
	assign q_pop = en && q_valid;

	assign re_in = q_data[QW-1 -: SW];
	assign im_in = q_data[QW-1-SW -: SW];
	assign seg_in = q_data[MF+SEG_W:MF+1];
	assign last_in = q_data[MF];
	assign cell_in = q_data[MF-1:0];

	assign s_cells = (MF+1)'(1) << cfg.cells_log2;
	assign sdiff = DW'(s_cells) - DW'(cfg.overlap);
	assign cell_x = DW'(cell_in);
	assign v_x = DW'(cfg.overlap);
	assign hv_x = DW'(cfg.overlap >> 1);
	assign hv2_x = DW'({cfg.overlap[OVL_W-1:1], 1'b0});
	assign prod_c = $signed({1'b0, seg_in}) * $signed(sdiff);
	assign cv_c = $signed(IW'(cell_in)) - $signed(IW'(cfg.overlap));
	assign keep_c = (seg_in == '0) ? (cell_x >= v_x)
		: ((cell_x >= hv_x && cell_x < hv2_x) || cell_x >= v_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			rt_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_abs_s1 <= mag_abs(re_in);
			im_abs_s1 <= mag_abs(im_in);
			last_s1 <= last_in;
			keep_s1 <= keep_c;
			prod_s1 <= prod_c;
			cv_s1 <= cv_c;

			sq_re_s2 <= SQW'(re_abs_s1) * SQW'(re_abs_s1);
			sq_im_s2 <= SQW'(im_abs_s1) * SQW'(im_abs_s1);
			last_s2 <= last_s1;
			keep_s2 <= keep_s1;
			idx_s2 <= prod_s1 + cv_s1;

			rt_rad_s[0] <= RADW'(sq_re_s2) + RADW'(sq_im_s2);
			rt_rem_s[0] <= '0;
			rt_root_s[0] <= '0;
			rt_last_s[0] <= last_s2;
			rt_ok_s[0] <= keep_s2 && !idx_s2[IW-1]
				&& (idx_s2[IW-2:0] < (IW-1)'(cfg.display_size));
			rt_idx_s[0] <= idx_s2[DISP_W-1:0];
		end
	end

	for (genvar k = 1; k <= R; k++) begin : g_root
		logic [TW-1:0] rem2;
		logic [TW-1:0] trial;
		logic ge;

		assign rem2 = {rt_rem_s[k-1], rt_rad_s[k-1][RADW-1 -: 2]};
		assign trial = TW'({rt_root_s[k-1], 2'b01});
		assign ge = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k] <= 1'b0;
			end else if (en) begin
				rt_v_s[k] <= rt_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rad_s[k] <= rt_rad_s[k-1] << 2;
				rt_rem_s[k] <= ge ? REMW'(rem2 - trial) : REMW'(rem2);
				rt_root_s[k] <= {rt_root_s[k-1][R-2:0], ge};
				rt_last_s[k] <= rt_last_s[k-1];
				rt_ok_s[k] <= rt_ok_s[k-1];
				rt_idx_s[k] <= rt_idx_s[k-1];
			end
		end
	end

	assign sum_next = sum_q + SUMW'(rt_root_s[R]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.clear) begin
				sum_q <= '0;
			end else if (en && rt_v_s[R]) begin
				sum_q <= rt_last_s[R] ? '0 : sum_next;
			end
			if (en) begin
				out_valid_q <= rt_v_s[R] && rt_last_s[R] && rt_ok_s[R];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && rt_v_s[R] && rt_last_s[R]) begin
			display_index_q <= rt_idx_s[R];
			level_q <= LEVEL_W'(sum_next >> cfg.gshift);
		end
	end

	assign out_valid = out_valid_q;
	assign display_index = display_index_q;
	assign level = level_q;

	a_stall_freezes_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !cfg.clear) |=> $stable(sum_q))
		else $error("accumulator moved while output stalled");
	a_result_only_on_group_end: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !(rt_v_s[R] && rt_last_s[R])) |=> !out_valid_q)
		else $error("result raised without a completed group");
	a_sum_cleared_after_group: assert property (@(posedge clk) disable iff (!arst_n)
		(en && rt_v_s[R] && rt_last_s[R]) |=> sum_q == '0)
		else $error("group sum not cleared after group end");

endmodule
